FILE: sv/ascon_pkg.sv
// Shared types, constants and helper functions for the Ascon permutation block.
// No dependencies; the round and top-level files in this folder import it.
package ascon_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned ROUND_W = 4;

    // Rounds are numbered 0 to 11; the block applies the last N of them.
    localparam logic [ROUND_W-1:0] MAX_ROUNDS = 4'd12;
    localparam logic [ROUND_W-1:0] MIN_ROUNDS = 4'd1;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd11;
    localparam logic [ROUND_W-1:0] RC_BASE    = 4'hf;

    typedef logic [WORD_W-1:0]     word_t;
    typedef logic [ROUND_W-1:0]    round_t;
    typedef word_t [4:0]           state_t;

    typedef struct packed {
        word_t  word_0;
        word_t  word_1;
        word_t  word_2;
        word_t  word_3;
        word_t  word_4;
        round_t round_count;
    } in_t;

    typedef struct packed {
        word_t out_word_0;
        word_t out_word_1;
        word_t out_word_2;
        word_t out_word_3;
        word_t out_word_4;
    } out_t;

    // Rotate right by a constant amount between 1 and 63.
    function automatic word_t rotr(input word_t v, input int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    // Round constant for round r: upper nibble counts down while the lower counts up.
    function automatic logic [7:0] round_const(input round_t r);
        round_t hi;
        hi = RC_BASE - r;
        return {hi, r};
    endfunction

endpackage

FILE: sv/ascon_round.sv
// One Ascon round: constant addition, bitsliced S-box and linear diffusion layer.
// Depends on ascon_pkg. Purely combinational; the sequencer registers its output.
module permute_round (
    input  ascon_pkg::state_t x,
    input  ascon_pkg::round_t round_idx,
    output ascon_pkg::state_t y
);
    import ascon_pkg::*;

    word_t a0, a1, a2, a3, a4;
    word_t b0, b1, b2, b3, b4;
    word_t c0, c1, c2, c3, c4;

    always_comb
    begin
        a0 = x[0];
        a1 = x[1];
        a2 = x[2] ^ {{(WORD_W-8){1'b0}}, round_const(round_idx)};
        a3 = x[3];
        a4 = x[4];

        // S-box input mixing.
        b0 = a0 ^ a4;
        b4 = a4 ^ a3;
        b2 = a2 ^ a1;
        b1 = a1;
        b3 = a3;

        // Chi-like nonlinear core.
        c0 = b0 ^ (~b1 & b2);
        c1 = b1 ^ (~b2 & b3);
        c2 = b2 ^ (~b3 & b4);
        c3 = b3 ^ (~b4 & b0);
        c4 = b4 ^ (~b0 & b1);

        // S-box output mixing.
        c1 = c1 ^ c0;
        c0 = c0 ^ c4;
        c3 = c3 ^ c2;
        c2 = ~c2;

        y[0] = c0 ^ rotr(c0, 19) ^ rotr(c0, 28);
        y[1] = c1 ^ rotr(c1, 61) ^ rotr(c1, 39);
        y[2] = c2 ^ rotr(c2, 1)  ^ rotr(c2, 6);
        y[3] = c3 ^ rotr(c3, 10) ^ rotr(c3, 17);
        y[4] = c4 ^ rotr(c4, 7)  ^ rotr(c4, 41);
    end

endmodule

FILE: sv/ascon_permutation.sv
// Top level of the Ascon permutation: round sequencer around one shared round unit.
// Depends on ascon_pkg and permute_round.
//
// Usage:
//   A transaction starts when start is high at a rising edge while busy is low.
//   The item port carries the five state words and a round count N; counts of
//   zero are treated as one round and counts above twelve as twelve. The block
//   applies the last N of the twelve Ascon rounds with a single round unit.
//   The first round is applied at the accepting edge and one more round at each
//   following edge. busy is high from the accepting edge until the last round is
//   applied, and then done is high for exactly one cycle with the permuted state
//   on result. The result port holds valid data only while done is high; the
//   receiver must take it in that cycle, since it cannot stall the block. busy is
//   already low during the done cycle, so a new start may be accepted then, but no
//   new transaction is taken while one is still running. Throughput is set by the
//   one round unit, used once a cycle.
//   Reset returns the sequencer to idle and drops done; no transaction survives it.
module ascon_permutation (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ascon_pkg::in_t   item,
    output logic             busy,
    output logic             done,
    output ascon_pkg::out_t  result
);
    import ascon_pkg::*;

    typedef enum logic {
        IDLE,
        RUN
    } seq_state_t;

    seq_state_t seq_reg,   seq_next;
    round_t     round_reg, round_next;
    logic       done_reg,  done_next;
    state_t     state_reg, state_next;

    state_t     unit_in;
    state_t     unit_out;
    round_t     unit_round;
    round_t     count_clamped;
    round_t     first_round;
    logic       accept;

    assign accept = start && (seq_reg == IDLE);

    always_comb
    begin
        priority if (item.round_count < MIN_ROUNDS)
            count_clamped = MIN_ROUNDS;
        else if (item.round_count > MAX_ROUNDS)
            count_clamped = MAX_ROUNDS;
        else
            count_clamped = item.round_count;
        first_round = MAX_ROUNDS - count_clamped;
    end

    // The round unit sees the fresh item on the accepting edge, else the working state.
    always_comb
    begin
        if (seq_reg == IDLE)
        begin
            unit_in[0] = item.word_0;
            unit_in[1] = item.word_1;
            unit_in[2] = item.word_2;
            unit_in[3] = item.word_3;
            unit_in[4] = item.word_4;
            unit_round = first_round;
        end
        else
        begin
            unit_in    = state_reg;
            unit_round = round_reg;
        end
    end

    permute_round u_round (
        .x         (unit_in),
        .round_idx (unit_round),
        .y         (unit_out)
    );

    always_comb
    begin
        seq_next   = seq_reg;
        round_next = round_reg;
        done_next  = 1'b0;
        state_next = state_reg;
        unique case (seq_reg)
            IDLE:
            begin
                if (accept)
                begin
                    state_next = unit_out;
                    round_next = first_round + 4'd1;
                    if (first_round == LAST_ROUND)
                        done_next = 1'b1;
                    else
                        seq_next = RUN;
                end
            end
            RUN:
            begin
                state_next = unit_out;
                round_next = round_reg + 4'd1;
                if (round_reg == LAST_ROUND)
                begin
                    done_next = 1'b1;
                    seq_next  = IDLE;
                end
            end
            default:
            begin
                seq_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            seq_reg   <= seq_next;
            round_reg <= round_next;
            done_reg  <= done_next;
            state_reg <= state_next;
        end
    end

    assign busy              = (seq_reg == RUN);
    assign done              = done_reg;
    assign result.out_word_0 = state_reg[0];
    assign result.out_word_1 = state_reg[1];
    assign result.out_word_2 = state_reg[2];
    assign result.out_word_3 = state_reg[3];
    assign result.out_word_4 = state_reg[4];

endmodule

FILE: sv/ascon_checker.sv
// Port-level checks on the start/busy/done sequencing of the Ascon permutation.
// Depends on ascon_permutation; attached to it by the bind statement below.
module ascon_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result is never shown while a transaction is still running.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done asserted while busy");

    // An accepted transaction either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted transaction neither running nor done");

    // The block only leaves the busy state by delivering a result.
    a_busy_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A result strobe lasts one cycle unless a one-round transaction was just accepted.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !start) |=> !done)
        else $error("done held longer than one cycle");

endmodule

bind ascon_permutation ascon_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
